@@ rtl/core/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared constants, types and the rotate helper for the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;

    typedef logic [31:0] t_word;

    // controller -> datapath commands
    typedef struct packed {
        logic load_byte;    // write the input byte, advance count
        logic pad_byte;     // write one padding byte at the fill position
        logic pad_mark;     // padding byte is the 0x80 marker
        logic len_byte;     // write one length byte at the fill position
        logic start_blk;    // load working vars from hash words
        logic do_round;     // run one round
        logic fold;         // add working vars into hash words
        logic clear_msg;    // restore initial hash, zero counters
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] round;
    } t_stat;

    localparam t_word HashInit [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ rtl/core/sha256_dp.sv @@
// ----------------------------------------------------------------------------
// sha256_dp
// Datapath: schedule window (also the block buffer), working vars, hash words,
// counters.
// ----------------------------------------------------------------------------
module sha256_dp
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_byte,
    input  logic [2:0]  i_word_sel,
    output t_stat       o_stat,
    output logic [31:0] o_word
);

    t_word       r_w   [16];
    t_word       r_v   [8];
    t_word       r_h   [8];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [5:0]  r_round;
    logic [2:0]  r_len_idx;

    t_word w_cur, s0, s1, t1, t2, w_new;
    logic [7:0] wr_byte;
    logic       wr_en;

    always_comb begin
        s0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = (r_round < 6'd16) ? r_w[0] : w_new;
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + RoundK[r_round] + w_cur;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        wr_en = i_cmd.load_byte | i_cmd.pad_byte | i_cmd.len_byte;
        priority if (i_cmd.load_byte) begin
            wr_byte = i_byte;
        end else if (i_cmd.len_byte) begin
            wr_byte = r_bits[63 - 8 * r_len_idx -: 8];
        end else if (i_cmd.pad_byte && i_cmd.pad_mark) begin
            wr_byte = 8'h80;
        end else begin
            wr_byte = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_bits    <= '0;
            r_round   <= '0;
            r_len_idx <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= HashInit[i];
        end else begin
            if (wr_en) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.load_byte) begin
                r_bits <= r_bits + 64'd8;
            end
            if (i_cmd.len_byte) begin
                r_len_idx <= r_len_idx + 3'd1;
            end
            if (i_cmd.do_round) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (i_cmd.clear_msg) begin
                r_fill    <= '0;
                r_bits    <= '0;
                r_len_idx <= '0;
                for (int i = 0; i < 8; i++) r_h[i] <= HashInit[i];
            end
        end
    end

    // bytes gather big-endian straight into the window; every block writes all 64
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_blk) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.do_round) begin
            // window shifts: slot 0 holds w[t] in rounds 0-15 and w[t-16] after
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_cur;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end else if (wr_en) begin
            r_w[r_fill[5:2]][31 - 8 * r_fill[1:0] -: 8] <= wr_byte;
        end
    end

    assign o_stat.fill       = r_fill;
    assign o_stat.round      = r_round;
    assign o_word            = r_h[i_word_sel];

endmodule

@@ rtl/core/sha256_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha256_ctrl
// Controller: sequences byte intake, padding, compressions and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_byte_valid,
    input  logic       i_last,
    output logic       o_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic [2:0] o_word_sel,
    output logic       o_out_valid,
    input  logic       i_out_ready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;   // 0x80 then zeros
    localparam logic [2:0] S_LEN   = 3'd2;   // eight length bytes
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_FOLD  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_closing, n_closing;   // message close in progress
    logic       r_first, n_first;       // next pad byte is the 0x80
    logic       r_final, n_final;       // current compression is the last
    logic       r_last_pend, n_last_pend;
    logic [2:0] r_widx, n_widx;

    always_comb begin
        n_state     = r_state;
        n_closing   = r_closing;
        n_first     = r_first;
        n_final     = r_final;
        n_last_pend = r_last_pend;
        n_widx      = r_widx;
        o_cmd       = '0;
        o_ready     = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_byte = i_byte_valid;
                    n_last_pend     = i_last;
                    n_first         = 1'b1;
                    if (i_byte_valid && i_stat.fill == 6'd63) begin
                        n_state = S_LOAD;
                        n_final = 1'b0;
                    end else if (i_last) begin
                        n_state   = S_PAD;
                        n_closing = 1'b1;
                    end
                end
            end
            S_PAD: begin
                if (!r_first && i_stat.fill == 6'd56) begin
                    n_state = S_LEN;
                end else begin
                    o_cmd.pad_byte = 1'b1;
                    o_cmd.pad_mark = r_first;
                    n_first        = 1'b0;
                    if (i_stat.fill == 6'd63) begin
                        n_state = S_LOAD;
                        n_final = 1'b0;
                    end
                end
            end
            S_LEN: begin
                o_cmd.len_byte = 1'b1;
                if (i_stat.fill == 6'd63) begin
                    n_state = S_LOAD;
                    n_final = 1'b1;
                end
            end
            S_LOAD: begin
                o_cmd.start_blk = 1'b1;
                n_state         = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.do_round = 1'b1;
                if (i_stat.round == 6'd63) n_state = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                if (r_final) begin
                    n_state = S_OUT;
                    n_widx  = '0;
                end else if (r_closing) begin
                    n_state = S_PAD;
                end else if (r_last_pend) begin
                    n_state   = S_PAD;
                    n_closing = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == 3'd7) begin
                        o_cmd.clear_msg = 1'b1;
                        n_state   = S_IDLE;
                        n_closing = 1'b0;
                        n_final   = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_word_sel = r_widx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_closing   <= 1'b0;
            r_first     <= 1'b0;
            r_final     <= 1'b0;
            r_last_pend <= 1'b0;
            r_widx      <= '0;
        end else begin
            r_state     <= n_state;
            r_closing   <= n_closing;
            r_first     <= n_first;
            r_final     <= n_final;
            r_last_pend <= n_last_pend;
            r_widx      <= n_widx;
        end
    end

endmodule

@@ rtl/core/sha256_message_digest_top.sv @@
// ----------------------------------------------------------------------------
// sha256_message_digest_top
// SHA-256 digest over a byte stream.
// ----------------------------------------------------------------------------
// Input channel (s_axis): one item per message byte. tdata[7:0] is the byte,
// tuser[0] says the byte is present, tlast closes the message.
// Output channel (m_axis): eight items per message, digest word 0 first;
// tdata is the 32-bit word, tuser[2:0] its index, tlast marks word 7.
// The 64th byte of a block starts a compression (load, 64 rounds on the
// single round unit, fold). A closing item pads one byte per cycle, with a
// pause before the eight length bytes in which nothing is written, and runs
// one or two compressions; the first digest word appears after the last
// fold. The block takes no input while a compression runs. While the digest
// waits on a stalled receiver the block holds each word and takes no input.
// Reset restores the initial hash values and clears byte and bit counts; the
// block is ready the cycle after reset.
// ----------------------------------------------------------------------------
module sha256_message_digest_top
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    t_cmd       cmd;
    t_stat      stat;
    logic [2:0] word_sel;

    sha256_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_byte_valid (s_axis_tuser),
        .i_last       (s_axis_tlast),
        .o_ready      (s_axis_tready),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_word_sel   (word_sel),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready)
    );

    sha256_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_byte     (s_axis_tdata),
        .i_word_sel (word_sel),
        .o_stat     (stat),
        .o_word     (m_axis_tdata)
    );

    assign m_axis_tuser = word_sel;
    assign m_axis_tlast = (word_sel == 3'd7);

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 message digest testbench
// Streams messages byte by byte into the digest block and checks every digest
// word against a SHA-256 computed alongside in the scoreboard. Covers the
// empty message, padding at the block boundaries, empty closing items and
// random messages under random idling and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
    import sha256_pkg::*;

    class digest_scoreboard;
        t_word       hash_q [8];
        logic [7:0]  blk [64];
        int unsigned fill;
        logic [63:0] bit_count;
        t_word       exp_word_q [$];
        logic [2:0]  exp_index_q [$];
        logic        exp_last_q [$];
        int          errors;

        function new();
            hash_q = HashInit;
            fill = 0;
            bit_count = '0;
            errors = 0;
        endfunction

        function t_word rr(t_word x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            t_word w [16];
            t_word v [8];
            t_word wt, t1, t2, w2, w15;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            v = hash_q;
            for (int r = 0; r < 64; r++) begin
                if (r < 16) begin
                    wt = w[r];
                end else begin
                    w2 = w[(r - 2) & 15];
                    w15 = w[(r - 15) & 15];
                    wt = (rr(w2, 17) ^ rr(w2, 19) ^ (w2 >> 10)) + w[(r - 7) & 15]
                        + (rr(w15, 7) ^ rr(w15, 18) ^ (w15 >> 3)) + w[r & 15];
                    w[r & 15] = wt;
                end
                t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                    + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + wt;
                t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                    + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                hash_q[i] += v[i];
        endfunction

        function void note_byte(logic [7:0] data, logic present, logic close);
            if (present) begin
                blk[fill] = data;
                bit_count += 64'd8;
                fill = (fill + 1) % 64;
                if (fill == 0)
                    compress();
            end
            if (!close)
                return;
            blk[fill] = 8'h80;
            for (int i = fill + 1; i < 64; i++)
                blk[i] = 8'h00;
            if (fill >= 56) begin
                compress();
                for (int i = 0; i < 56; i++)
                    blk[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                blk[56 + i] = bit_count[63 - 8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                exp_word_q.push_back(hash_q[i]);
                exp_index_q.push_back(3'(i));
                exp_last_q.push_back(i == 7);
            end
            hash_q = HashInit;
            fill = 0;
            bit_count = '0;
        endfunction

        function void check_word(t_word word, logic [2:0] index, logic last);
            if (exp_word_q.size() == 0) begin
                $error("digest word with nothing expected: %h", word);
                errors++;
                return;
            end
            if (word !== exp_word_q[0]) begin
                $error("digest_word expected %h actual %h", exp_word_q[0], word);
                errors++;
            end
            if (index !== exp_index_q[0]) begin
                $error("word_index expected %0d actual %0d", exp_index_q[0], index);
                errors++;
            end
            if (last !== exp_last_q[0]) begin
                $error("last_word expected %0d actual %0d", exp_last_q[0], last);
                errors++;
            end
            void'(exp_word_q.pop_front());
            void'(exp_index_q.pop_front());
            void'(exp_last_q.pop_front());
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] byte_valid
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] digest_word
    logic [2:0]  m_axis_tuser;   // [2:0] word_index
    logic        m_axis_tlast;   // last_word

    sha256_message_digest_top DUT (.*);

    digest_scoreboard sb = new();
    int unsigned send_idle_pct = 31;
    int unsigned recv_idle_pct = 82;
    bit          recv_hold = 0;
    int unsigned quiet_cycles = 0;
    localparam int unsigned QuietLimit = 20000;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // receiver: random stalls, or a full hold while recv_hold is set
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("sha256_message_digest_top: mismatch");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] data, logic present, logic close);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= present;
        s_axis_tlast  <= close;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic go_quiet();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.exp_word_q.size() != 0)
            @(posedge i_clk);
    endtask

    // random content; the closing byte is present or absent at random (always absent for len 0)
    task automatic send_message(int unsigned len);
        logic empty_close;
        empty_close = $urandom_range(1);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom), 1'b1, !empty_close && i == len - 1);
        if (empty_close || len == 0)
            send_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int unsigned len;
        int unsigned pad_lens [2];
        pad_lens      = '{56, 64};
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, then "abc"
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h61, 1'b1, 1'b0);
        send_byte(8'h62, 1'b1, 1'b0);
        send_byte(8'h63, 1'b1, 1'b1);
        // bytes with neither flag are ignored mid-message
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h5a, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'ha5, 1'b0, 1'b1);
        go_quiet();

        // padding lengths around the block edges
        foreach (pad_lens[k])
            send_message(pad_lens[k]);
        go_quiet();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 31 : phase == 1 ? 82 : 0;
            recv_idle_pct = phase == 0 ? 82 : phase == 1 ? 31 : 0;
            for (int m = 0; m < 3; m++) begin
                len = $urandom_range(7);
                if ($urandom_range(15) == 0)
                    send_byte(8'($urandom), 1'b0, 1'b0);
                send_message(len);
            end
            if (phase == 1) begin
                // long output stall while input keeps coming
                recv_hold = 1;
                fork
                    begin
                        repeat (400) @(posedge i_clk);
                        recv_hold = 0;
                    end
                    begin
                        send_message(3);
                        send_message(5);
                    end
                join
            end
            go_quiet();
        end

        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.exp_word_q.size() == 0)
            $display("sha256_message_digest_top: match");
        else
            $display("sha256_message_digest_top: mismatch");
        $finish;
    end
endmodule
